// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PSG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("phased sine generator assertion failed");

// A condition that must never be seen at a clock edge outside reset.
`define PSG_NEVER(lbl, expr) \
	`PSG_ASSERT(lbl, !(expr))

`endif

// ===== rtl/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// Phased sine generator package
// Types, command and status structs and fixed constants of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

	// Serial frame header.
	localparam logic [7:0] HEADER_BYTE = 8'h75;

	// Configuration register indexes.
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_WAIT   = 1'b1;

	localparam int CFG_W        = 20;
	localparam int WAIT_W       = 16;
	localparam int WORD_W       = 16;
	localparam int ANGLE_W      = 16;
	localparam int ANGLE_FIELDS = 5;
	localparam int JOINT_W      = 3;
	localparam int ACC_BITS     = 48;
	localparam int MUL_W        = 48;
	localparam int PROD_W       = 64;
	localparam int COEF_W       = 40;

	// Time step in turns with 48 fractional bits, scaled by 2^8.
	localparam logic [MUL_W-1:0] TIME_RECIP = MUL_W'(64'd114683223);
	// Phase step scale, turns with 48 fractional bits per word unit.
	localparam logic [MUL_W-1:0] PHI_RECIP  = MUL_W'(64'd447981339000);

	// Odd Taylor coefficients of sine in Q30, lowest order first.
	localparam logic signed [COEF_W-1:0] SINE_COEF [5] = '{
		40'sd1686629713, -40'sd693598668, 40'sd85569306, -40'sd5026995, 40'sd172272
	};

	// Sequencer steps; each one is a product in the shared multiplier.
	typedef enum logic [3:0] {
		OP_FP,
		OP_INC,
		OP_INCN,
		OP_PH,
		OP_X2,
		OP_H3,
		OP_H2,
		OP_H1,
		OP_H0,
		OP_Y,
		OP_AMP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic byte_in;
		logic tick_in;
		logic start_run;
		logic mul_start;
		logic wb;
		logic next_joint;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic in_wait;
		logic last_joint;
	} ctl_stat_t;

endpackage

// ===== rtl/psg_mul.sv =====
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Unsigned 48 by 48 product, low 64 bits, one bit of the multiplier per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [psg_pkg::MUL_W-1:0]  a,
	input  logic [psg_pkg::MUL_W-1:0]  b,
	output logic                       busy,
	output logic                       done,
	output logic [psg_pkg::PROD_W-1:0] prod
);
	import psg_pkg::*;

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PROD_W-1:0] a_q;
	logic [MUL_W-1:0]  b_q;
	logic [PROD_W-1:0] p_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(MUL_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// One partial product is added per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= PROD_W'(a);
			b_q <= b;
			p_q <= '0;
		end else if (cnt_q != '0) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign prod = p_q;

endmodule

// ===== rtl/psg_datapath.sv =====
// ----------------------------------------------------------------------------
// Phased sine generator datapath
// Frame parser, configuration, tick count, phase and sine arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_datapath #(
	parameter int NUM_JOINTS = 5,
	parameter int PHASE_BITS = 24,
	parameter int TICK_BITS  = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  psg_pkg::ctl_cmd_t                        cmd,
	output psg_pkg::ctl_stat_t                       stat,
	input  logic [7:0]                               s_tdata,
	input  logic                                     cfg_we,
	input  logic                                     cfg_index,
	input  logic [psg_pkg::CFG_W-1:0]                cfg_data,
	output logic [psg_pkg::ANGLE_FIELDS*psg_pkg::ANGLE_W-1:0] m_tdata,
	output logic                                     m_tuser
);
	import psg_pkg::*;

	localparam int ACTIVE = (NUM_JOINTS < ANGLE_FIELDS) ? NUM_JOINTS : ANGLE_FIELDS;
	localparam logic [31:0] PMASK = ~(32'hFFFF_FFFF >> PHASE_BITS);

	logic [CFG_W-1:0]     period_q;
	logic [WAIT_W-1:0]    wait_q;
	logic [2:0]           idx_q;
	logic [7:0]           cap_q [5];
	logic [WORD_W-1:0]    amp_q;
	logic [WORD_W-1:0]    phs_q;
	logic [WORD_W-1:0]    frq_q;
	logic [TICK_BITS-1:0] tick_q;
	logic [TICK_BITS-1:0] n_q;
	logic [35:0]          t_q;
	logic [ACC_BITS-1:0]  inc_q;
	logic [ACC_BITS-1:0]  theta_q;
	logic [ACC_BITS-1:0]  ph_q;
	logic [30:0]          x2_q;
	logic signed [COEF_W-1:0] acc_q;
	logic [16:0]          smag_q;
	logic [JOINT_W-1:0]   k_q;
	logic                 moving_q;
	logic [ANGLE_W-1:0]   angle_q [ANGLE_FIELDS];
	logic [ANGLE_FIELDS*ANGLE_W-1:0] out_q;
	logic                 out_moving_q;

	logic [2:0]           idx_d;
	logic [31:0]          p32;
	logic [30:0]          x31;
	logic [COEF_W-1:0]    acc_mag;
	logic signed [COEF_W-1:0] r_s;
	logic signed [COEF_W-1:0] horner;
	logic [30:0]          y31;
	logic [16:0]          v;
	logic [ANGLE_W-1:0]   sat;
	logic [MUL_W-1:0]     op_a;
	logic [MUL_W-1:0]     op_b;
	logic [PROD_W-1:0]    prod;
	logic                 mul_busy;
	logic                 mul_done;

	// Coefficient used by each Horner step.
	function automatic logic signed [COEF_W-1:0] coef_of(op_t op);
		unique case (op)
			OP_H3:   return SINE_COEF[3];
			OP_H2:   return SINE_COEF[2];
			OP_H1:   return SINE_COEF[1];
			default: return SINE_COEF[0];
		endcase
	endfunction

	// Quarter-turn fold of the current joint phase.
	assign p32     = theta_q[ACC_BITS-1 -: 32] & PMASK;
	assign x31     = p32[30] ? (31'h4000_0000 - {1'b0, p32[29:0]}) : {1'b0, p32[29:0]};
	assign acc_mag = acc_q[COEF_W-1] ? COEF_W'(-acc_q) : COEF_W'(acc_q);

	// Signed Q30 product and the next Horner term.
	assign r_s    = $signed({6'd0, prod[63:30]});
	assign horner = coef_of(cmd.op) + (acc_q[COEF_W-1] ? -r_s : r_s);

	// Sine clamp to [0, 2^30].
	always_comb begin
		if (acc_q[COEF_W-1] || prod[63:30] == '0) begin
			y31 = '0;
		end else if (prod[63:30] > 34'h4000_0000) begin
			y31 = 31'h4000_0000;
		end else begin
			y31 = prod[60:30];
		end
	end

	// Amplitude scaling with saturation to signed 16 bits.
	assign v = prod[32:16];
	always_comb begin
		if (p32[31]) begin
			sat = (v > 17'd32768) ? 16'h8000 : 16'(-v);
		end else begin
			sat = (v > 17'd32767) ? 16'h7FFF : v[15:0];
		end
	end

	// Multiplier operands for each step.
	always_comb begin
		unique case (cmd.op)
			OP_FP:   begin op_a = MUL_W'(frq_q);   op_b = MUL_W'(period_q); end
			OP_INC:  begin op_a = MUL_W'(t_q);     op_b = TIME_RECIP;       end
			OP_INCN: begin op_a = inc_q;           op_b = MUL_W'(n_q);      end
			OP_PH:   begin op_a = MUL_W'(phs_q);   op_b = PHI_RECIP;        end
			OP_X2:   begin op_a = MUL_W'(x31);     op_b = MUL_W'(x31);      end
			OP_Y:    begin op_a = MUL_W'(acc_mag); op_b = MUL_W'(x31);      end
			OP_AMP:  begin op_a = MUL_W'(amp_q);   op_b = MUL_W'(smag_q);   end
			default: begin op_a = MUL_W'(acc_mag); op_b = MUL_W'(x2_q);     end
		endcase
	end

	psg_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (op_a),
		.b     (op_b),
		.busy  (mul_busy),
		.done  (mul_done),
		.prod  (prod)
	);

	// Parser index after a byte; a header outside a capture starts a new one.
	always_comb begin
		if (idx_q != 3'd0 && idx_q <= 3'd6) begin
			idx_d = (idx_q == 3'd6) ? 3'd0 : idx_q + 3'd1;
		end else begin
			idx_d = 3'd0;
		end
		if (s_tdata == HEADER_BYTE && idx_d == 3'd0) begin
			idx_d = 3'd1;
		end
	end

	// Configuration, parser and tick count state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= CFG_W'(10000);
			wait_q   <= '0;
			idx_q    <= '0;
			amp_q    <= '0;
			phs_q    <= '0;
			frq_q    <= '0;
			tick_q   <= '0;
			for (int j = 0; j < 5; j++) begin
				cap_q[j] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PERIOD) begin
					period_q <= cfg_data;
				end else begin
					wait_q <= cfg_data[WAIT_W-1:0];
				end
			end
			if (cmd.byte_in) begin
				idx_q <= idx_d;
				for (int j = 0; j < 5; j++) begin
					if (idx_q == 3'(j + 1)) begin
						cap_q[j] <= s_tdata;
					end
				end
				if (idx_q == 3'd6) begin
					amp_q <= {cap_q[0], cap_q[1]};
					phs_q <= {cap_q[2], cap_q[3]};
					frq_q <= {cap_q[4], s_tdata};
				end
			end
			if (cmd.tick_in) begin
				tick_q <= tick_q + 1'b1;
			end
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		if (cmd.start_run) begin
			n_q      <= tick_q - TICK_BITS'(wait_q);
			moving_q <= !stat.in_wait;
			k_q      <= '0;
			for (int j = 0; j < ANGLE_FIELDS; j++) begin
				angle_q[j] <= '0;
			end
		end
		if (cmd.next_joint) begin
			theta_q <= theta_q + ph_q;
			k_q     <= k_q + 1'b1;
		end
		if (cmd.wb) begin
			unique case (cmd.op)
				OP_FP:   t_q     <= prod[35:0];
				OP_INC:  inc_q   <= prod[55:8];
				OP_INCN: theta_q <= prod[ACC_BITS-1:0];
				OP_PH:   ph_q    <= prod[ACC_BITS-1:0];
				OP_X2: begin
					x2_q  <= prod[60:30];
					acc_q <= SINE_COEF[4];
				end
				OP_Y:    smag_q  <= y31[30:14];
				OP_AMP:  angle_q[k_q] <= sat;
				default: acc_q   <= horner;
			endcase
		end
		if (cmd.out_load) begin
			for (int j = 0; j < ANGLE_FIELDS; j++) begin
				out_q[j*ANGLE_W +: ANGLE_W] <= angle_q[j];
			end
			out_moving_q <= moving_q;
		end
	end

	assign stat.mul_busy   = mul_busy;
	assign stat.mul_done   = mul_done;
	assign stat.in_wait    = (tick_q <= TICK_BITS'(wait_q));
	assign stat.last_joint = (k_q == JOINT_W'(ACTIVE - 1));
	assign m_tdata = out_q;
	assign m_tuser = out_moving_q;

endmodule

// ===== rtl/psg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Phased sine generator controller
// Sequences the handshakes and the multiplier steps of one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	output psg_pkg::ctl_cmd_t  cmd,
	input  psg_pkg::ctl_stat_t stat
);
	import psg_pkg::*;

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   valid_q;
	logic   accept;
	logic   out_free;

	// A request is taken only while no tick is being worked on.
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !valid_q || m_tready;

	// Next state and next step.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = stat.in_wait ? ST_DONE : ST_ISSUE;
				op_d    = OP_FP;
			end
			ST_ISSUE: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.mul_done) begin
					state_d = ST_ISSUE;
					if (op_q == OP_AMP) begin
						if (stat.last_joint) begin
							state_d = ST_DONE;
						end else begin
							op_d = OP_X2;
						end
					end else begin
						op_d = op_t'(op_q + 1'b1);
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd            = '0;
		cmd.op         = op_q;
		cmd.byte_in    = accept && !s_tuser;
		cmd.tick_in    = accept && s_tuser;
		cmd.start_run  = (state_q == ST_CHECK);
		cmd.mul_start  = (state_q == ST_ISSUE);
		cmd.wb         = (state_q == ST_WAIT) && stat.mul_done;
		cmd.next_joint = cmd.wb && (op_q == OP_AMP) && !stat.last_joint;
		cmd.out_load   = (state_q == ST_DONE) && out_free;
	end

	// State, step and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_FP;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;

	`PSG_NEVER(a_start_busy, cmd.mul_start && stat.mul_busy)
	`PSG_ASSERT(a_done_in_wait, stat.mul_done |-> state_q == ST_WAIT)
	`PSG_ASSERT(a_tick_check, (s_tvalid && s_tready && s_tuser) |=> state_q == ST_CHECK)
endmodule

// ===== rtl/phased_sine_wave_generator.sv =====
// A byte request gives no result.
// A tick in the wait goes from the check state straight to the done state.
// A moving tick runs 4 + 7 * joints products, one at a time, in the
// shared shift-add multiplier. One request is worked on at a time.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Phased sine wave generator
// Parses parameter frames and turns ticks into phased joint angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phased_sine_wave_generator #(
	parameter int NUM_JOINTS = 5,
	parameter int PHASE_BITS = 24,
	parameter int TICK_BITS  = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // rx_byte
	input  logic                        s_tuser,  // cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [79:0]                 m_tdata,  // angle_0 .. angle_4
	output logic                        m_tuser,  // moving
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [psg_pkg::CFG_W-1:0]   cfg_data
);
	import psg_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// Sequencer.
	psg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	// Arithmetic and state.
	psg_datapath #(
		.NUM_JOINTS(NUM_JOINTS),
		.PHASE_BITS(PHASE_BITS),
		.TICK_BITS (TICK_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== dv/tb_phased_sine_wave_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phased sine wave generator testbench
// Streams parameter frames, noise bytes and ticks into the generator under
// random sender gaps and receiver stalls. A local fixed-point model predicts
// every joint angle set, and the monitor checks each result against it.
// ----------------------------------------------------------------------------

module tb_phased_sine_wave_generator;
	import psg_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 4000;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} req_t;

	typedef struct packed {
		logic [79:0] angles;
		logic        moving;
	} angle_set_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [79:0]         m_tdata;
	logic                m_tuser;
	logic                cfg_we = 1'b0;
	logic                cfg_index = REG_PERIOD;
	logic [CFG_W-1:0]    cfg_data = '0;

	req_t       pending_reqs[$];
	angle_set_t expected_angles[$];

	// Model state of the generator.
	logic [19:0] mdl_period;
	logic [15:0] mdl_wait;
	int          mdl_idx;
	logic [7:0]  mdl_bytes[6];
	logic [15:0] mdl_amp;
	logic [15:0] mdl_phase;
	logic [15:0] mdl_freq;
	logic [31:0] mdl_ticks;

	int err_count = 0;
	int results_seen = 0;
	int moving_seen = 0;
	int items_sent = 0;
	int frames_sent = 0;

	phased_sine_wave_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// (a * b) / 2^30 with truncation toward zero.
	function automatic longint mul_q30(longint a, longint b);
		logic            neg;
		longint unsigned m;
		longint unsigned r;
		neg = a < 0;
		m = neg ? longint'(-a) : a;
		r = (m * longint'(b)) >> 30;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// Sine of a Q0.24 turn, returned with 16 fractional bits.
	function automatic int sine_q16(logic [23:0] ph);
		longint     taylor[5];
		logic [31:0] p32;
		logic [1:0] quad;
		longint     x;
		longint     x2;
		longint     acc;
		longint     y;
		taylor = '{1686629713, -693598668, 85569306, -5026995, 172272};
		p32 = {ph, 8'h00};
		quad = p32[31:30];
		x = longint'(p32[29:0]);
		if (quad[0]) begin
			x = (64'sd1 << 30) - x;
		end
		x2 = (x * x) >>> 30;
		acc = taylor[4];
		for (int i = 3; i >= 0; i--) begin
			acc = taylor[i] + mul_q30(acc, x2);
		end
		y = mul_q30(acc, x);
		if (y < 0) y = 0;
		if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
		y = y >>> 14;
		return quad[1] ? -int'(y) : int'(y);
	endfunction

	// Amplitude times sine, truncated and saturated to 16 bits.
	function automatic logic [15:0] joint_angle(int s);
		longint unsigned m;
		longint unsigned v;
		m = (s < 0) ? longint'(-s) : longint'(s);
		v = (longint'(mdl_amp) * m) >> 16;
		if (s < 0) begin
			return (v > 32768) ? 16'h8000 : 16'(-v);
		end
		return (v > 32767) ? 16'h7fff : 16'(v);
	endfunction

	// Advance the model by one accepted request.
	task automatic predict_request(req_t rq);
		angle_set_t      res;
		longint unsigned n;
		longint unsigned inc;
		longint unsigned ph;
		longint unsigned theta;
		if (!rq.cmd) begin
			if (mdl_idx > 0 && mdl_idx <= 6) begin
				mdl_bytes[mdl_idx - 1] = rq.data;
				mdl_idx++;
				if (mdl_idx > 6) begin
					mdl_idx = 0;
					mdl_amp = {mdl_bytes[0], mdl_bytes[1]};
					mdl_phase = {mdl_bytes[2], mdl_bytes[3]};
					mdl_freq = {mdl_bytes[4], mdl_bytes[5]};
				end
			end else begin
				mdl_idx = 0;
			end
			if (rq.data == HEADER_BYTE && mdl_idx == 0) mdl_idx = 1;
		end else begin
			mdl_ticks = mdl_ticks + 32'd1;
			res = '0;
			if (mdl_ticks > {16'h0, mdl_wait}) begin
				n = longint'(mdl_ticks - {16'h0, mdl_wait});
				inc = (longint'(mdl_freq) * longint'(mdl_period) * 64'd114683223) >> 8;
				ph = longint'(mdl_phase) * 64'd447981339000;
				for (int k = 0; k < ANGLE_FIELDS; k++) begin
					theta = (inc * n + longint'(k) * ph) & 64'hffff_ffff_ffff;
					res.angles[16*k +: 16] = joint_angle(sine_q16(theta[47:24]));
				end
				res.moving = 1'b1;
			end
			expected_angles.push_back(res);
		end
	endtask

	// Request driver: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		logic nxt_valid;
		req_t nxt;
		nxt_valid = s_tvalid;
		nxt = '{s_tuser, s_tdata};
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_request('{s_tuser, s_tdata});
				items_sent++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					nxt_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
		s_tvalid <= nxt_valid;
		s_tuser <= nxt.cmd;
		s_tdata <= nxt.data;
	end

	// Receiver stall pattern, with one long hold after the first results.
	int stall_mode = 0;
	int stall_seg = 0;
	int hold_count = 0;
	logic hold_done = 1'b0;
	always @(posedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (!hold_done && results_seen >= 20) begin
			hold_count++;
			rdy = 1'b0;
			if (hold_count >= LONG_HOLD) hold_done <= 1'b1;
		end else begin
			if (stall_seg == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_seg = $urandom_range(5, 200);
			end else begin
				stall_seg--;
			end
			case (stall_mode)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 3) != 0);
				default: rdy = ($urandom_range(0, 3) == 0);
			endcase
		end
		m_tready <= rdy;
	end

	// Result checker against the oldest predicted angle set.
	always @(posedge clk) begin
		angle_set_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_angles.size() == 0) begin
				err_count++;
				if (err_count <= 10) $display("unexpected result %h moving %b", m_tdata, m_tuser);
			end else begin
				want = expected_angles.pop_front();
				if (want.moving) moving_seen++;
				for (int k = 0; k < ANGLE_FIELDS; k++) begin
					if (m_tdata[16*k +: 16] !== want.angles[16*k +: 16]) begin
						err_count++;
						if (err_count <= 10) begin
							$display("angle_%0d mismatch: expected %0d got %0d", k,
								$signed(want.angles[16*k +: 16]), $signed(m_tdata[16*k +: 16]));
						end
					end
				end
				if (m_tuser !== want.moving) begin
					err_count++;
					if (err_count <= 10) begin
						$display("moving mismatch: expected %b got %b", want.moving, m_tuser);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_phased_sine_wave_generator: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_byte(logic [7:0] b);
		pending_reqs.push_back('{1'b0, b});
	endtask

	task automatic queue_frame(logic [15:0] amp, logic [15:0] phs, logic [15:0] frq);
		queue_byte(HEADER_BYTE);
		queue_byte(amp[15:8]);
		queue_byte(amp[7:0]);
		queue_byte(phs[15:8]);
		queue_byte(phs[7:0]);
		queue_byte(frq[15:8]);
		queue_byte(frq[7:0]);
		frames_sent++;
	endtask

	// Wait for the pipeline to drain, then let the parser settle.
	task automatic drain;
		while (pending_reqs.size() > 0 || s_tvalid || expected_angles.size() > 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_PERIOD) mdl_period = val;
		else mdl_wait = val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed frames with random content, plus ticks and noise.
	task automatic queue_random(int count);
		int  made;
		int  pick;
		logic [15:0] amp;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				amp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 200)) : 16'($urandom);
				if ($urandom_range(0, 5) == 0) begin
					queue_frame(amp, 16'($urandom), {8'($urandom), HEADER_BYTE});
				end else begin
					queue_frame(amp, 16'($urandom), 16'($urandom));
				end
				made += 7;
			end else if (pick < 75) begin
				pending_reqs.push_back('{1'b1, 8'($urandom)});
				made++;
			end else begin
				queue_byte(8'($urandom));
				made++;
			end
		end
	endtask

	task automatic tick;
		pending_reqs.push_back('{1'b1, 8'h00});
	endtask

	initial begin
		mdl_period = 20'd10000;
		mdl_wait = '0;
		mdl_idx = 0;
		mdl_bytes = '{default: 8'h00};
		mdl_amp = '0;
		mdl_phase = '0;
		mdl_freq = '0;
		mdl_ticks = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, a frame ending in a header, and a tick at reset words.
		tick;
		queue_byte(8'h00);
		queue_frame(16'hffff, 16'hffff, 16'hffff);
		tick;
		queue_frame(16'h7fff, 16'h0001, {8'h00, HEADER_BYTE});
		tick;
		queue_byte(8'h00);
		queue_byte(8'h64);
		queue_byte(8'h00);
		queue_byte(8'h9d);
		queue_byte(8'h01);
		queue_byte(8'h3a);
		tick;
		drain();

		// Default registers.
		queue_random(175);
		drain();

		// Zero period gives constant phase; wait starts a few ticks ahead.
		write_reg(REG_PERIOD, '0);
		write_reg(REG_WAIT, 20'(mdl_ticks + 32'd5));
		queue_random(175);
		drain();

		// Shortest nonzero period and the longest wait: every tick stays at rest.
		write_reg(REG_PERIOD, 20'd1);
		write_reg(REG_WAIT, 20'hffff);
		queue_random(100);
		drain();

		// Longest period and a random one, wait at or just ahead of the count.
		write_reg(REG_PERIOD, 20'hfffff);
		write_reg(REG_WAIT, 20'(mdl_ticks + 32'd2));
		queue_random(125);
		drain();
		write_reg(REG_PERIOD, 20'($urandom_range(1, 1000000)));
		write_reg(REG_WAIT, 20'(mdl_ticks));
		queue_random(125);
		drain();
		repeat (50) @(posedge clk);

		$display("Sent %0d requests with %0d frames; checked %0d angle sets, %0d moving.",
			items_sent, frames_sent, results_seen, moving_seen);
		if (expected_angles.size() > 0) err_count++;
		if (err_count == 0) begin
			$display("tb_phased_sine_wave_generator: clean");
		end else begin
			$display("tb_phased_sine_wave_generator: errors");
		end
		$finish;
	end

endmodule
